// ===== rtl/ikch_pkg.sv =====
// shared types, widths and status codes for the integer-key hash table
`default_nettype none
package ikch_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int STATUS_W       = 2;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value_out;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/ikch_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
`default_nettype none
module ikch_ram #(
  parameter int DEPTH = ikch_pkg::TABLE_SIZE_DEF,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, read every cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/int_key_coalesced_hash_table.sv =====
// Find reads the home slot on accept and follows the chain until the key matches, the chain
// ends or all slots were visited. Insert writes a free home slot, else probes triangularly
// for a free slot and links it in after the home slot. Each chain step or probe is one read
// of the slot memories; a request waits for the previous one to complete. A full table is
// found at the home check or when all probes fail; reset clears valid/link memory, busy high.
// TABLE_SIZE must be a power of two; results cannot be stalled by the receiver.
`default_nettype none
module int_key_coalesced_hash_table #(
  parameter int TABLE_SIZE = ikch_pkg::TABLE_SIZE_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire ikch_pkg::req_t req,
  output logic              done,
  output ikch_pkg::res_t    res
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int LINK_W = $clog2(TABLE_SIZE + 1);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int META_W = LINK_W + 1;
  localparam int ENT_W  = ikch_pkg::KEY_W + ikch_pkg::VAL_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FCHK   = 3'd2;
  localparam logic [2:0] S_IHOME  = 3'd3;
  localparam logic [2:0] S_IPROBE = 3'd4;
  localparam logic [2:0] S_ILINK  = 3'd5;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

  logic [2:0]                  state;
  logic [IDX_W-1:0]            clr_idx;
  logic [ikch_pkg::KEY_W-1:0]  key_r;
  logic [ikch_pkg::VAL_W-1:0]  value_r;
  logic [IDX_W-1:0]            cur;
  logic [IDX_W-1:0]            pos;
  logic [IDX_W-1:0]            step;
  logic [LINK_W-1:0]           home_link;
  logic [CNT_W-1:0]            count;

  logic [IDX_W-1:0]  raddr;
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_q;
  logic              ent_we;
  logic [ENT_W-1:0]  ent_q;

  logic                       slot_valid;
  logic [LINK_W-1:0]          slot_link;
  logic [ikch_pkg::KEY_W-1:0] slot_key;
  logic [ikch_pkg::VAL_W-1:0] slot_value;
  logic [LINK_W-1:0]          link_m1;
  logic [IDX_W-1:0]           chain_next;
  logic [IDX_W-1:0]           probe_next;
  logic                       table_full;
  logic                       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // unpack memory read data
  assign slot_valid = meta_q[LINK_W];
  assign slot_link  = meta_q[LINK_W-1:0];
  assign slot_key   = ent_q[ENT_W-1 -: ikch_pkg::KEY_W];
  assign slot_value = ent_q[ikch_pkg::VAL_W-1:0];

  // next chain slot and next triangular probe position
  assign link_m1    = slot_link - LINK_W'(1);
  assign chain_next = link_m1[IDX_W-1:0];
  assign probe_next = pos + step + IDX_W'(1);
  assign table_full = (count >= CNT_W'(TABLE_SIZE));

  // read address: both memories are read at the same slot
  always_comb begin
    case (state)
      S_IDLE:   raddr = req.key[IDX_W-1:0];
      S_FCHK:   raddr = chain_next;
      S_IHOME:  raddr = cur + IDX_W'(1);
      S_IPROBE: raddr = probe_next;
      default:  raddr = cur;
    endcase
  end

  // write ports
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = cur;
    meta_wdata = {1'b1, slot_link};
    ent_we     = 1'b0;
    case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        meta_wdata = '0;
      end
      S_IHOME: begin
        if (!table_full && !slot_valid) begin
          meta_we = 1'b1;
          ent_we  = 1'b1;
        end
      end
      S_IPROBE: begin
        meta_waddr = pos;
        meta_wdata = {1'b1, home_link};
        if (!slot_valid) begin
          meta_we = 1'b1;
          ent_we  = 1'b1;
        end
      end
      S_ILINK: begin
        meta_we    = 1'b1;
        meta_wdata = {1'b1, LINK_W'(pos) + LINK_W'(1)};
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  // valid bit and successor link per slot
  ikch_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (META_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (raddr),
    .rdata (meta_q)
  );

  // key and value per slot
  ikch_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (ENT_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (meta_waddr),
    .wdata ({key_r, value_r}),
    .raddr (raddr),
    .rdata (ent_q)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            key_r   <= req.key;
            value_r <= req.value;
            cur     <= req.key[IDX_W-1:0];
            step    <= '0;
            state   <= (req.op == ikch_pkg::OP_INSERT) ? S_IHOME : S_FCHK;
          end
        end
        S_FCHK: begin
          if (slot_valid && slot_key == key_r) begin
            done          <= 1'b1;
            res.status    <= ikch_pkg::ST_OK;
            res.value_out <= slot_value;
            state         <= S_IDLE;
          end else if (!slot_valid || slot_link == '0 || step == IDX_LAST) begin
            done          <= 1'b1;
            res.status    <= ikch_pkg::ST_MISS;
            res.value_out <= '0;
            state         <= S_IDLE;
          end else begin
            cur  <= chain_next;
            step <= step + IDX_W'(1);
          end
        end
        S_IHOME: begin
          if (table_full) begin
            done          <= 1'b1;
            res.status    <= ikch_pkg::ST_FULL;
            res.value_out <= '0;
            state         <= S_IDLE;
          end else if (!slot_valid) begin
            count         <= count + CNT_W'(1);
            done          <= 1'b1;
            res.status    <= ikch_pkg::ST_OK;
            res.value_out <= '0;
            state         <= S_IDLE;
          end else begin
            home_link <= slot_link;
            pos       <= cur + IDX_W'(1);
            step      <= '0;
            state     <= S_IPROBE;
          end
        end
        S_IPROBE: begin
          if (!slot_valid) begin
            state <= S_ILINK;
          end else if (step == IDX_LAST) begin
            done          <= 1'b1;
            res.status    <= ikch_pkg::ST_FULL;
            res.value_out <= '0;
            state         <= S_IDLE;
          end else begin
            pos  <= probe_next;
            step <= step + IDX_W'(1);
          end
        end
        S_ILINK: begin
          count         <= count + CNT_W'(1);
          done          <= 1'b1;
          res.status    <= ikch_pkg::ST_OK;
          res.value_out <= '0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ikch_check.sv =====
// port-level checks for the integer-key hash table, bound to the top level
`default_nettype none
module ikch_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire ikch_pkg::res_t res
);

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("not busy after accepted transaction");

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // done is set only when a working state returns to idle, so strobes never touch
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // status code is always a defined one
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.status == ikch_pkg::ST_OK || res.status == ikch_pkg::ST_MISS ||
              res.status == ikch_pkg::ST_FULL))
    else $error("undefined status code");

  // payload is zero unless the transaction succeeded
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    done && res.status != ikch_pkg::ST_OK |-> res.value_out == '0)
    else $error("nonzero payload on failed transaction");

endmodule

bind int_key_coalesced_hash_table ikch_check u_ikch_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
`default_nettype wire
